### rtl/bfm_pkg.sv
package bfm_pkg;

	localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
	localparam logic [63:0] MUR_SEED = 64'h0000_0000_9747_b28c;
	localparam int          MUR_R    = 47;
	localparam int          ROT_L    = 31;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_WRITE  = 2'd3;

	localparam logic CFG_NUM_BITS   = 1'b0;
	localparam logic CFG_NUM_HASHES = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_MIX   = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_POST  = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_RD    = 7'b1000000
	} state_t;

	typedef enum logic [4:0] {
		MOP_SEED = 5'b00001,
		MOP_K1   = 5'b00010,
		MOP_K2   = 5'b00100,
		MOP_H    = 5'b01000,
		MOP_FIN  = 5'b10000
	} mop_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key_word;
		logic [3:0]  word_bytes;
		logic [10:0] key_length;
		logic        last_word;
		logic [12:0] byte_index;
		logic [7:0]  byte_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] done_action;
		logic       maybe_present;
	} res_t;

endpackage

### rtl/bfm_mul.sv
module bfm_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] prod
);

	// Low 64 bits of a * M from three 32x32 partial products, one per cycle.
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [1:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] p;

	always_comb begin
		x = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		y = (step_q == 2'd1) ? bfm_pkg::MUR_M[63:32] : bfm_pkg::MUR_M[31:0];
		p = {32'b0, x} * {32'b0, y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= 2'd0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				if (step_q == 2'd2) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end else if (run_q) begin
			if (step_q == 2'd0) begin
				acc_q <= p;
			end else begin
				acc_q <= acc_q + {p[31:0], 32'b0};
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### rtl/bfm_store.sv
module bfm_store #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/bloom_filter_murmur64_unit.sv
// Bloom filter with MurmurHash64A keys; one word at a time, busy while it works.
// Byte write: done in the cycle after start. Clear: zeroes every byte of the store, then done.
// Key word: busy while it passes through the shared 64-bit multiplier; the last word adds a
// finalising multiply plus, for each probe, a run of the 1-bit-per-cycle remainder unit.
// After reset the store is cleared with busy high.
// Each result is a one-cycle done strobe; the receiver cannot stall it.
module bloom_filter_murmur64_unit #(
	parameter int MAX_BITS   = 65536,
	parameter int MAX_HASHES = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bfm_pkg::cmd_t   cmd,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [16:0]     cfg_data,
	output logic            done,
	output bfm_pkg::res_t   result
);

	localparam int STORE_BYTES = MAX_BITS / 8;
	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [24:0] MB = 25'(MAX_BITS);
	localparam logic [6:0] MH = 7'(MAX_HASHES);
	localparam logic [24:0] SB = 25'(STORE_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

	bfm_pkg::state_t state_q;
	bfm_pkg::mop_t   mop_q;

	logic [16:0] num_bits_q;
	logic [5:0]  num_hashes_q;
	logic [63:0] acc_q;
	logic        inside_q;
	logic        rst_clr_q;
	logic [AW-1:0] clr_q;

	logic [1:0]  act_q;
	logic [63:0] word_q;
	logic [3:0]  nb_q;
	logic        last_q;
	logic [63:0] h_q;
	logic [63:0] h2_q;
	logic [63:0] pb_q;
	logic [63:0] sh_q;
	logic [16:0] rem_q;
	logic [5:0]  cnt_q;
	logic [5:0]  i_q;
	logic        all_q;
	logic [16:0] idx_q;

	logic        mstart_q;
	logic [63:0] ma_q;
	logic        mul_done;
	logic        mul_done_d;
	logic [63:0] mul_res;

	logic        done_q;
	bfm_pkg::res_t res_q;

	logic [16:0] m_eff;
	logic [5:0]  k_eff;
	logic [17:0] trial;
	logic [16:0] rem_nx;
	logic [13:0] pbyte;
	logic [31:0] pbyte_x;
	logic [31:0] bidx_x;
	logic        p_in;
	logic        b_in;
	logic [63:0] tail_mask;
	logic [63:0] fin_h;
	logic [63:0] next_pb;
	logic        accept;
	logic [7:0]  bit_mask;
	logic [7:0]  rdata;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic [AW-1:0] mem_ra;

	assign mul_done_d = mul_done;

	always_comb begin
		m_eff = ({8'b0, num_bits_q} > MB) ? MB[16:0] : num_bits_q;
		k_eff = ({1'b0, num_hashes_q} > MH) ? MH[5:0] : num_hashes_q;
		trial = {rem_q, sh_q[63]};
		rem_nx = (trial >= {1'b0, m_eff}) ? 17'(trial - {1'b0, m_eff}) : trial[16:0];
		pbyte = rem_nx[16:3];
		pbyte_x = {18'b0, pbyte};
		p_in = ({11'b0, pbyte} < SB);
		bidx_x = {19'b0, cmd.byte_index};
		b_in = ({12'b0, cmd.byte_index} < SB);
		tail_mask = ~(64'hffff_ffff_ffff_ffff << {nb_q[2:0], 3'b000});
		fin_h = mul_res ^ (mul_res >> bfm_pkg::MUR_R);
		next_pb = pb_q + h2_q;
		accept = start && (state_q == bfm_pkg::ST_IDLE);
		bit_mask = 8'b1 << idx_q[2:0];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = 8'b0;
		mem_ra = pbyte_x[AW-1:0];
		case (state_q)
			bfm_pkg::ST_IDLE: begin
				if (accept && cmd.action == bfm_pkg::ACT_WRITE) begin
					mem_we = b_in;
					mem_wa = bidx_x[AW-1:0];
					mem_wd = cmd.byte_value;
				end
			end
			bfm_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			bfm_pkg::ST_RD: begin
				mem_we = (act_q == bfm_pkg::ACT_INSERT);
				mem_wa = pbyte_x[AW-1:0];
				mem_wd = rdata | bit_mask;
			end
			default: begin
			end
		endcase
		if (state_q == bfm_pkg::ST_RD) begin
			mem_wa = AW'({18'b0, idx_q[16:3]});
		end
	end

	bfm_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_wa),
		.wdata(mem_wd),
		.raddr(mem_ra),
		.rdata(rdata)
	);

	bfm_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mstart_q),
		.a     (ma_q),
		.done  (mul_done),
		.prod  (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bfm_pkg::ST_CLEAR;
			mop_q        <= bfm_pkg::MOP_SEED;
			num_bits_q   <= 17'b0;
			num_hashes_q <= 6'b0;
			acc_q        <= 64'b0;
			inside_q     <= 1'b0;
			rst_clr_q    <= 1'b1;
			clr_q        <= '0;
			mstart_q     <= 1'b0;
			ma_q         <= 64'b0;
			done_q       <= 1'b0;
		end else begin
			mstart_q <= 1'b0;
			done_q   <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == bfm_pkg::CFG_NUM_BITS) begin
					num_bits_q <= cfg_data;
				end else begin
					num_hashes_q <= cfg_data[5:0];
				end
			end
			case (state_q)
				bfm_pkg::ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							bfm_pkg::ACT_CLEAR: begin
								clr_q   <= '0;
								state_q <= bfm_pkg::ST_CLEAR;
							end
							bfm_pkg::ACT_WRITE: begin
								done_q <= 1'b1;
							end
							default: begin
								if (inside_q) begin
									state_q <= bfm_pkg::ST_MIX;
								end else begin
									ma_q     <= {53'b0, cmd.key_length};
									mstart_q <= 1'b1;
									mop_q    <= bfm_pkg::MOP_SEED;
									state_q  <= bfm_pkg::ST_MUL;
								end
							end
						endcase
					end
				end
				bfm_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						done_q    <= !rst_clr_q;
						rst_clr_q <= 1'b0;
						state_q   <= bfm_pkg::ST_IDLE;
					end
				end
				bfm_pkg::ST_MIX: begin
					if (nb_q[3]) begin
						ma_q     <= word_q;
						mstart_q <= 1'b1;
						mop_q    <= bfm_pkg::MOP_K1;
						state_q  <= bfm_pkg::ST_MUL;
					end else if (nb_q != 4'd0) begin
						ma_q     <= h_q ^ (word_q & tail_mask);
						mstart_q <= 1'b1;
						mop_q    <= bfm_pkg::MOP_H;
						state_q  <= bfm_pkg::ST_MUL;
					end else begin
						state_q <= bfm_pkg::ST_POST;
					end
				end
				bfm_pkg::ST_POST: begin
					if (!last_q) begin
						acc_q    <= h_q;
						inside_q <= 1'b1;
						state_q  <= bfm_pkg::ST_IDLE;
					end else begin
						acc_q    <= 64'b0;
						inside_q <= 1'b0;
						ma_q     <= h_q ^ (h_q >> bfm_pkg::MUR_R);
						mstart_q <= 1'b1;
						mop_q    <= bfm_pkg::MOP_FIN;
						state_q  <= bfm_pkg::ST_MUL;
					end
				end
				bfm_pkg::ST_MUL: begin
					if (mul_done_d) begin
						case (mop_q)
							bfm_pkg::MOP_SEED: begin
								state_q <= bfm_pkg::ST_MIX;
							end
							bfm_pkg::MOP_K1: begin
								ma_q     <= fin_h;
								mstart_q <= 1'b1;
								mop_q    <= bfm_pkg::MOP_K2;
							end
							bfm_pkg::MOP_K2: begin
								ma_q     <= h_q ^ mul_res;
								mstart_q <= 1'b1;
								mop_q    <= bfm_pkg::MOP_H;
							end
							bfm_pkg::MOP_H: begin
								state_q <= bfm_pkg::ST_POST;
							end
							default: begin
								if (m_eff == 17'd0 || k_eff == 6'd0) begin
									done_q  <= 1'b1;
									state_q <= bfm_pkg::ST_IDLE;
								end else begin
									state_q <= bfm_pkg::ST_DIV;
								end
							end
						endcase
					end
				end
				bfm_pkg::ST_DIV: begin
					if (cnt_q == 6'd63) begin
						state_q <= p_in ? bfm_pkg::ST_RD : bfm_pkg::ST_DIV;
						if (!p_in && i_q == k_eff - 6'd1) begin
							done_q  <= 1'b1;
							state_q <= bfm_pkg::ST_IDLE;
						end
					end
				end
				bfm_pkg::ST_RD: begin
					if (i_q == k_eff - 6'd1) begin
						done_q  <= 1'b1;
						state_q <= bfm_pkg::ST_IDLE;
					end else begin
						state_q <= bfm_pkg::ST_DIV;
					end
				end
				default: begin
					state_q <= bfm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the probe position is rebuilt as h1 + i*h2 by repeated adds.
	always_ff @(posedge clk) begin
		case (state_q)
			bfm_pkg::ST_IDLE: begin
				if (accept) begin
					res_q.done_action   <= cmd.action;
					res_q.maybe_present <= 1'b0;
					act_q  <= cmd.action;
					word_q <= cmd.key_word;
					nb_q   <= (cmd.word_bytes > 4'd8) ? 4'd8 : cmd.word_bytes;
					last_q <= cmd.last_word;
					h_q    <= acc_q;
				end
			end
			bfm_pkg::ST_MIX: begin
				if (!nb_q[3] && nb_q != 4'd0) begin
					h_q <= h_q ^ (word_q & tail_mask);
				end
			end
			bfm_pkg::ST_MUL: begin
				if (mul_done_d) begin
					case (mop_q)
						bfm_pkg::MOP_SEED: begin
							h_q <= bfm_pkg::MUR_SEED ^ mul_res;
						end
						bfm_pkg::MOP_K2: begin
							h_q <= h_q ^ mul_res;
						end
						bfm_pkg::MOP_H: begin
							h_q <= mul_res;
						end
						bfm_pkg::MOP_FIN: begin
							res_q.maybe_present <= (act_q == bfm_pkg::ACT_QUERY);
							h2_q  <= {fin_h[32:0], fin_h[63:33]};
							pb_q  <= fin_h;
							sh_q  <= fin_h;
							rem_q <= 17'b0;
							cnt_q <= 6'd0;
							i_q   <= 6'd0;
							all_q <= 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			bfm_pkg::ST_DIV: begin
				rem_q <= rem_nx;
				sh_q  <= {sh_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					idx_q <= rem_nx;
					rem_q <= 17'b0;
					if (!p_in) begin
						i_q  <= i_q + 6'd1;
						pb_q <= next_pb;
						sh_q <= next_pb;
					end
				end
			end
			bfm_pkg::ST_RD: begin
				if (act_q == bfm_pkg::ACT_QUERY) begin
					if ((rdata & bit_mask) == 8'b0) begin
						res_q.maybe_present <= 1'b0;
						all_q <= 1'b0;
					end else begin
						res_q.maybe_present <= all_q;
					end
				end
				i_q   <= i_q + 6'd1;
				pb_q  <= next_pb;
				sh_q  <= next_pb;
				cnt_q <= 6'd0;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != bfm_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
